[rtl/segint_pkg.sv]
// shared widths and pipeline types for the segment intersection test unit
// no dependencies

package segint_pkg;

    localparam int W_COORD = 16;                  // Q12.4 coordinate
    localparam int N_COORD = 8;                   // coordinates per input transfer
    localparam int W_DIFF  = W_COORD + 1;         // coordinate difference
    localparam int W_PROD  = 2 * W_DIFF;          // product of two differences
    localparam int W_SUM   = W_PROD + 1;          // denominator and numerators
    localparam int W_MAG   = W_SUM;               // magnitude of a sum
    localparam int W_FRAC  = 16;                  // fraction bits of a position
    localparam int W_POS   = 32;                  // Q15.16 position
    localparam int W_REM   = W_MAG + W_FRAC;      // scaled numerator magnitude
    localparam int W_CMP   = W_MAG + W_POS;       // divisor shifted by a quotient bit
    localparam int W_IN    = N_COORD * W_COORD;
    localparam int W_OUT   = 2 * W_POS;
    localparam int W_FLAGS = 2;

    localparam logic [W_POS-1:0] POS_MAX = {1'b0, {(W_POS-1){1'b1}}};
    localparam logic [W_POS-1:0] POS_MIN = {1'b1, {(W_POS-1){1'b0}}};

    typedef struct packed {
        logic signed [W_DIFF-1:0] rx;
        logic signed [W_DIFF-1:0] ry;
        logic signed [W_DIFF-1:0] ux;
        logic signed [W_DIFF-1:0] uy;
        logic signed [W_DIFF-1:0] dx;
        logic signed [W_DIFF-1:0] dy;
    } t_diff;

    typedef struct packed {
        logic signed [W_PROD-1:0] rx_uy;
        logic signed [W_PROD-1:0] ux_ry;
        logic signed [W_PROD-1:0] uy_dx;
        logic signed [W_PROD-1:0] ux_dy;
        logic signed [W_PROD-1:0] ry_dx;
        logic signed [W_PROD-1:0] rx_dy;
    } t_prod;

    typedef struct packed {
        logic signed [W_SUM-1:0] den;
        logic signed [W_SUM-1:0] n1;
        logic signed [W_SUM-1:0] n2;
    } t_sum;

    typedef struct packed {
        logic [W_REM-1:0] rem1;
        logic [W_REM-1:0] rem2;
        logic [W_MAG-1:0] dvs;
        logic [W_POS-1:0] q1;
        logic [W_POS-1:0] q2;
        logic             neg1;
        logic             neg2;
        logic             ovf1;
        logic             ovf2;
        logic             par;
        logic             crs;
    } t_div_stage;

endpackage

[rtl/segment_intersection_test_unit.sv]
// segment intersection test: differences, products, sums, then a one bit per stage divider
// depends on segint_pkg
//
// throughput: one segment pair per cycle when the output is not stalled
// the restoring divider is pipelined over 32 stages, one quotient bit per stage
// each stage moves on when the one after it is empty or moving, so bubbles close up
// reset (i_rst_n low, synchronous) empties every stage; payload registers are not reset

module segment_intersection_test_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // fields from bit 0: first_start_x, first_start_y, first_end_x, first_end_y,
    // second_start_x, second_start_y, second_end_x, second_end_y
    input  logic [segint_pkg::W_IN-1:0]     i_s_tdata,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // fields from bit 0: position_first, position_second
    output logic [segint_pkg::W_OUT-1:0]    o_m_tdata,
    // fields from bit 0: crosses, parallel
    output logic [segint_pkg::W_FLAGS-1:0]  o_m_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready
);

    localparam int N_DIV = segint_pkg::W_POS;

    logic                   r_v_diff, r_v_prod, r_v_sum;
    segint_pkg::t_diff      r_diff, n_diff;
    segint_pkg::t_prod      r_prod;
    segint_pkg::t_sum       r_sum;
    logic [N_DIV:0]         r_v_div;
    segint_pkg::t_div_stage r_div [N_DIV+1];
    segint_pkg::t_div_stage n_div [N_DIV+1];
    logic [N_DIV:0]         rdy_div;
    logic                   rdy_out, rdy_sum, rdy_prod, rdy_diff;
    logic [segint_pkg::W_OUT-1:0]   n_tdata;
    logic [segint_pkg::W_FLAGS-1:0] n_tuser;

    // ready chain, back from the output register
    always_comb begin
        rdy_out = !o_m_tvalid || i_m_tready;
        rdy_div[N_DIV] = !r_v_div[N_DIV] || rdy_out;
        for (int j = N_DIV - 1; j >= 0; j--) begin
            rdy_div[j] = !r_v_div[j] || rdy_div[j+1];
        end
        rdy_sum  = !r_v_sum  || rdy_div[0];
        rdy_prod = !r_v_prod || rdy_sum;
        rdy_diff = !r_v_diff || rdy_prod;
    end

    assign o_s_tready = rdy_diff;

    // stage 1: direction vectors and start offset
    always_comb begin
        logic signed [segint_pkg::W_DIFF-1:0] c [segint_pkg::N_COORD];
        for (int k = 0; k < segint_pkg::N_COORD; k++) begin
            c[k] = segint_pkg::W_DIFF'($signed(
                i_s_tdata[k*segint_pkg::W_COORD +: segint_pkg::W_COORD]));
        end
        n_diff.rx = c[2] - c[0];
        n_diff.ry = c[3] - c[1];
        n_diff.ux = c[6] - c[4];
        n_diff.uy = c[7] - c[5];
        n_diff.dx = c[4] - c[0];
        n_diff.dy = c[5] - c[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_diff <= 1'b0;
            r_v_prod <= 1'b0;
            r_v_sum  <= 1'b0;
        end else begin
            if (rdy_diff) r_v_diff <= i_s_tvalid;
            if (rdy_prod) r_v_prod <= r_v_diff;
            if (rdy_sum)  r_v_sum  <= r_v_prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_diff && i_s_tvalid) r_diff <= n_diff;
        // stage 2: six products
        if (rdy_prod && r_v_diff) begin
            r_prod.rx_uy <= r_diff.rx * r_diff.uy;
            r_prod.ux_ry <= r_diff.ux * r_diff.ry;
            r_prod.uy_dx <= r_diff.uy * r_diff.dx;
            r_prod.ux_dy <= r_diff.ux * r_diff.dy;
            r_prod.ry_dx <= r_diff.ry * r_diff.dx;
            r_prod.rx_dy <= r_diff.rx * r_diff.dy;
        end
        // stage 3: denominator and numerators
        if (rdy_sum && r_v_prod) begin
            r_sum.den <= segint_pkg::W_SUM'(r_prod.rx_uy) - segint_pkg::W_SUM'(r_prod.ux_ry);
            r_sum.n1  <= segint_pkg::W_SUM'(r_prod.uy_dx) - segint_pkg::W_SUM'(r_prod.ux_dy);
            r_sum.n2  <= segint_pkg::W_SUM'(r_prod.ry_dx) - segint_pkg::W_SUM'(r_prod.rx_dy);
        end
    end

    // stage 4: magnitudes, signs, interval test and overflow check
    always_comb begin
        logic [segint_pkg::W_MAG-1:0] m_den, m_n1, m_n2;
        logic                         s_den, s_n1, s_n2, in1, in2;
        s_den = r_sum.den[segint_pkg::W_SUM-1];
        s_n1  = r_sum.n1[segint_pkg::W_SUM-1];
        s_n2  = r_sum.n2[segint_pkg::W_SUM-1];
        m_den = s_den ? segint_pkg::W_MAG'(-r_sum.den) : segint_pkg::W_MAG'(r_sum.den);
        m_n1  = s_n1  ? segint_pkg::W_MAG'(-r_sum.n1)  : segint_pkg::W_MAG'(r_sum.n1);
        m_n2  = s_n2  ? segint_pkg::W_MAG'(-r_sum.n2)  : segint_pkg::W_MAG'(r_sum.n2);
        in1 = (m_n1 == '0) || ((s_n1 == s_den) && (m_n1 <= m_den));
        in2 = (m_n2 == '0) || ((s_n2 == s_den) && (m_n2 <= m_den));
        n_div[0].par  = (m_den == '0);
        n_div[0].crs  = in1 && in2 && (m_den != '0);
        n_div[0].dvs  = m_den;
        n_div[0].rem1 = {m_n1, {segint_pkg::W_FRAC{1'b0}}};
        n_div[0].rem2 = {m_n2, {segint_pkg::W_FRAC{1'b0}}};
        n_div[0].neg1 = s_n1 ^ s_den;
        n_div[0].neg2 = s_n2 ^ s_den;
        // quotient of 2^32 or more cannot fit the position
        n_div[0].ovf1 = segint_pkg::W_CMP'(n_div[0].rem1)
                        >= {m_den, {segint_pkg::W_POS{1'b0}}};
        n_div[0].ovf2 = segint_pkg::W_CMP'(n_div[0].rem2)
                        >= {m_den, {segint_pkg::W_POS{1'b0}}};
        n_div[0].q1   = '0;
        n_div[0].q2   = '0;
    end

    // restoring division, quotient bit N_DIV-1-j in stage j+1
    for (genvar j = 0; j < N_DIV; j++) begin : g_div
        localparam int BIT = N_DIV - 1 - j;
        always_comb begin
            logic [segint_pkg::W_CMP-1:0] sh, e1, e2;
            sh = segint_pkg::W_CMP'(r_div[j].dvs) << BIT;
            e1 = segint_pkg::W_CMP'(r_div[j].rem1);
            e2 = segint_pkg::W_CMP'(r_div[j].rem2);
            n_div[j+1] = r_div[j];
            if (e1 >= sh) begin
                n_div[j+1].rem1    = segint_pkg::W_REM'(e1 - sh);
                n_div[j+1].q1[BIT] = 1'b1;
            end
            if (e2 >= sh) begin
                n_div[j+1].rem2    = segint_pkg::W_REM'(e2 - sh);
                n_div[j+1].q2[BIT] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_div <= '0;
        end else begin
            if (rdy_div[0]) r_v_div[0] <= r_v_sum;
            for (int j = 0; j < N_DIV; j++) begin
                if (rdy_div[j+1]) r_v_div[j+1] <= r_v_div[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_div[0] && r_v_sum) r_div[0] <= n_div[0];
        for (int j = 0; j < N_DIV; j++) begin
            if (rdy_div[j+1] && r_v_div[j]) r_div[j+1] <= n_div[j+1];
        end
    end

    // saturation and sign
    function automatic logic [segint_pkg::W_POS-1:0] sat_pos(
        input logic [segint_pkg::W_POS-1:0] mag,
        input logic                         neg,
        input logic                         ovf
    );
        logic [segint_pkg::W_POS-1:0] res;
        if (neg) begin
            res = (ovf || mag > segint_pkg::POS_MIN) ? segint_pkg::POS_MIN : -mag;
        end else begin
            res = (ovf || mag[segint_pkg::W_POS-1]) ? segint_pkg::POS_MAX : mag;
        end
        return res;
    endfunction

    always_comb begin
        if (r_div[N_DIV].par) begin
            n_tdata = '0;
        end else begin
            n_tdata = {sat_pos(r_div[N_DIV].q2, r_div[N_DIV].neg2, r_div[N_DIV].ovf2),
                       sat_pos(r_div[N_DIV].q1, r_div[N_DIV].neg1, r_div[N_DIV].ovf1)};
        end
        n_tuser = {r_div[N_DIV].par, r_div[N_DIV].crs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_m_tvalid <= 1'b0;
        end else if (rdy_out) begin
            o_m_tvalid <= r_v_div[N_DIV];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_out && r_v_div[N_DIV]) begin
            o_m_tdata <= n_tdata;
            o_m_tuser <= n_tuser;
        end
    end

    a_parallel_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[1] |-> !o_m_tuser[0] && o_m_tdata == '0)
        else $error("parallel result with crossing or non-zero position");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && r_v_div == '0 && !r_v_diff)
        else $error("pipeline not empty after reset");

    a_no_loss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v_div[N_DIV] && !rdy_out |=> r_v_div[N_DIV] && $stable(r_div[N_DIV].q1))
        else $error("last divider stage dropped a stalled item");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v_diff |-> o_s_tready)
        else $error("input stage empty but not ready");

endmodule
